### src/v3n_pkg.sv
package v3n_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Sum of three squares and its root.
  localparam int SUM_BITS  = 2 * WORD_BITS;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int SREM_BITS = ROOT_BITS + 2;
  // Rounded quotient numerator: magnitude shifted up plus half the divisor.
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS + 1;
  localparam int DREM_BITS = WORD_BITS + 1;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_NORM  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] scalar;
  } item_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [1:0]  status;
  } result_t;

  // Operands and early results that ride along with each item.
  typedef struct packed {
    logic [2:0]                 mode;
    logic [2:0]                 neg;
    logic [2:0][WORD_BITS-1:0]  ma;
    logic [WORD_BITS-1:0]       ms;
    logic [2:0][WORD_BITS-1:0]  re;
    logic                       sat;
    logic                       zero;
  } side_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  v;
    logic [SREM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [2:0][QUO_BITS-1:0]  num;
    logic [ROOT_BITS-1:0]      den;
    logic [2:0][DREM_BITS-1:0] rem;
  } dv_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] v;
    logic                 sat;
  } clamp_t;

  function automatic clamp_t clamp_mag(input logic neg, input logic [QUO_BITS-1:0] m);
    logic [QUO_BITS-1:0] lim;
    logic [QUO_BITS-1:0] mm;
    logic [QUO_BITS-1:0] sv;
    clamp_t c;
    lim = QUO_BITS'(1) << (WORD_BITS - 1);
    if (!neg) begin
      lim = lim - QUO_BITS'(1);
    end
    c.sat = (m > lim);
    mm = c.sat ? lim : m;
    sv = neg ? (~mm + QUO_BITS'(1)) : mm;
    c.v = sv[WORD_BITS-1:0];
    return c;
  endfunction

endpackage

### src/v3n_sqrt_cell.sv
module v3n_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  v3n_pkg::sq_t     din,
  input  v3n_pkg::side_t   sin,
  output logic             vout,
  output v3n_pkg::sq_t     dout,
  output v3n_pkg::side_t   sout
);

  localparam int TW = v3n_pkg::SREM_BITS + 2;

  logic [TW-1:0] t;
  logic [TW-1:0] trial;
  logic          take;
  v3n_pkg::sq_t  nxt;

  // One result bit per cell: bring down two bits of the radicand, try 4*root+1.
  always_comb begin
    t     = {din.rem, din.v[v3n_pkg::SUM_BITS-1 -: 2]};
    trial = TW'({din.root, 2'b01});
    take  = (t >= trial);
    nxt.v    = din.v << 2;
    nxt.rem  = take ? v3n_pkg::SREM_BITS'(t - trial) : v3n_pkg::SREM_BITS'(t);
    nxt.root = {din.root[v3n_pkg::ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
      sout <= sin;
    end
  end

endmodule

### src/v3n_div_cell.sv
module v3n_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  v3n_pkg::dv_t     din,
  input  v3n_pkg::side_t   sin,
  output logic             vout,
  output v3n_pkg::dv_t     dout,
  output v3n_pkg::side_t   sout
);

  localparam int TW = v3n_pkg::DREM_BITS + 1;

  logic [2:0][TW-1:0] t;
  logic [2:0]         take;
  v3n_pkg::dv_t       nxt;

  // One restoring step per lane; quotient bits shift in where numerator bits leave.
  always_comb begin
    nxt.den = din.den;
    for (int i = 0; i < 3; i++) begin
      t[i]       = {din.rem[i], din.num[i][v3n_pkg::QUO_BITS-1]};
      take[i]    = (t[i] >= TW'(din.den));
      nxt.rem[i] = take[i] ? v3n_pkg::DREM_BITS'(t[i] - TW'(din.den))
                           : v3n_pkg::DREM_BITS'(t[i]);
      nxt.num[i] = {din.num[i][v3n_pkg::QUO_BITS-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
      sout <= sin;
    end
  end

endmodule

### src/vector3_arithmetic_normalize.sv
// Three-component Q16.16 vector unit: add, subtract, scale, divide by a scalar,
// or normalize to unit length, with saturation and a status code per result.
// The unit takes one item per cycle unless stalled and runs it through a chain
// of registers: four operand stages (input, magnitudes and add/subtract, one
// multiplier per component, square sum and scale rounding), 32 square-root
// cells that each settle one root bit, one divisor setup stage, 49 divider
// cells that each settle one quotient bit for all three components at once,
// and the output register. Every item runs the whole chain whatever its mode,
// so results leave in order. The chain moves as one: while a result waits in
// the output register under stall, nothing advances and item_stall is high;
// otherwise an item is taken every cycle.
module vector3_arithmetic_normalize (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  v3n_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output v3n_pkg::result_t  result
);

  localparam int W  = v3n_pkg::WORD_BITS;
  localparam int F  = v3n_pkg::FRAC_BITS;
  localparam int SB = v3n_pkg::SUM_BITS;
  localparam int QB = v3n_pkg::QUO_BITS;
  localparam int NS = v3n_pkg::ROOT_BITS;
  localparam int ND = v3n_pkg::QUO_BITS;

  logic en;

  // The whole chain advances unless a finished result is held by stall.
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // Stage A: the transferred item.
  logic           va;
  v3n_pkg::item_t ia;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia <= item;
    end
  end

  // Stage B: magnitudes, result signs, and the add/subtract results.
  logic                  vb;
  v3n_pkg::side_t        sb;
  v3n_pkg::side_t        sb_next;
  logic [2:0][W-1:0]     av;
  logic [2:0][W-1:0]     bv;
  logic [W:0]            asum;
  logic [W:0]            amag;
  v3n_pkg::clamp_t       acl;
  logic                  neg_s;

  always_comb begin
    av[0] = ia.a_x[W-1:0];
    av[1] = ia.a_y[W-1:0];
    av[2] = ia.a_z[W-1:0];
    bv[0] = ia.b_x[W-1:0];
    bv[1] = ia.b_y[W-1:0];
    bv[2] = ia.b_z[W-1:0];
    neg_s = ia.scalar[W-1];
    sb_next.mode = ia.mode;
    sb_next.ms   = neg_s ? (~ia.scalar[W-1:0] + W'(1)) : ia.scalar[W-1:0];
    sb_next.zero = (ia.mode == v3n_pkg::MODE_DIV) && (ia.scalar[W-1:0] == '0);
    sb_next.sat  = 1'b0;
    asum = '0;
    amag = '0;
    acl  = '0;
    for (int i = 0; i < 3; i++) begin
      sb_next.ma[i]  = av[i][W-1] ? (~av[i] + W'(1)) : av[i];
      sb_next.neg[i] = (ia.mode == v3n_pkg::MODE_NORM) ? av[i][W-1]
                                                         : (av[i][W-1] ^ neg_s);
      if (ia.mode == v3n_pkg::MODE_SUB) begin
        asum = {av[i][W-1], av[i]} - {bv[i][W-1], bv[i]};
      end else begin
        asum = {av[i][W-1], av[i]} + {bv[i][W-1], bv[i]};
      end
      amag = asum[W] ? (~asum + (W+1)'(1)) : asum;
      acl  = v3n_pkg::clamp_mag(asum[W], QB'(amag));
      if (ia.mode == v3n_pkg::MODE_ADD || ia.mode == v3n_pkg::MODE_SUB) begin
        sb_next.re[i] = acl.v;
        sb_next.sat   = sb_next.sat | acl.sat;
      end else begin
        sb_next.re[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb <= sb_next;
    end
  end

  // Stage C: one product per component, a*s for scale and a*a otherwise.
  logic               vc;
  v3n_pkg::side_t     sc;
  logic [2:0][SB-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc <= sb;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= SB'(sb.ma[i]) *
                   SB'((sb.mode == v3n_pkg::MODE_SCALE) ? sb.ms : sb.ma[i]);
      end
    end
  end

  // Stage D: sum of squares, and the rounded and clamped scale results.
  logic               vd;
  v3n_pkg::side_t     sd;
  v3n_pkg::side_t     sd_next;
  logic [SB-1:0]      sum;
  logic [SB-1:0]      sum_next;
  logic [SB-1:0]      pr;
  v3n_pkg::clamp_t    pcl;

  always_comb begin
    sd_next  = sc;
    sum_next = prod[0] + prod[1] + prod[2];
    pr  = '0;
    pcl = '0;
    if (sc.mode == v3n_pkg::MODE_SCALE) begin
      for (int i = 0; i < 3; i++) begin
        pr  = (prod[i] + (SB'(1) << (F - 1))) >> F;
        pcl = v3n_pkg::clamp_mag(sc.neg[i], QB'(pr));
        sd_next.re[i] = pcl.v;
        sd_next.sat   = sd_next.sat | pcl.sat;
      end
    end
    if (sc.mode == v3n_pkg::MODE_NORM) begin
      sd_next.zero = (sum_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd  <= sd_next;
      sum <= sum_next;
    end
  end

  // Square-root chain.
  logic            sq_v [NS+1];
  v3n_pkg::sq_t    sq_d [NS+1];
  v3n_pkg::side_t  sq_s [NS+1];

  assign sq_v[0]      = vd;
  assign sq_d[0].v    = sum;
  assign sq_d[0].rem  = '0;
  assign sq_d[0].root = '0;
  assign sq_s[0]      = sd;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (sq_v[g]),
      .din  (sq_d[g]),
      .sin  (sq_s[g]),
      .vout (sq_v[g+1]),
      .dout (sq_d[g+1]),
      .sout (sq_s[g+1])
    );
  end

  // Stage E: divisor choice and rounded numerators (magnitude shifted up plus half
  // the divisor).
  logic            ve;
  v3n_pkg::side_t  se;
  v3n_pkg::dv_t    de;
  v3n_pkg::dv_t    de_next;

  always_comb begin
    de_next.den = (sq_s[NS].mode == v3n_pkg::MODE_DIV) ? v3n_pkg::ROOT_BITS'(sq_s[NS].ms)
                                                        : sq_d[NS].root;
    for (int i = 0; i < 3; i++) begin
      de_next.num[i] = (QB'(sq_s[NS].ma[i]) << F) + QB'(de_next.den >> 1);
      de_next.rem[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se <= sq_s[NS];
      de <= de_next;
    end
  end

  // Divider chain, three lanes wide.
  logic            dv_v [ND+1];
  v3n_pkg::dv_t    dv_d [ND+1];
  v3n_pkg::side_t  dv_s [ND+1];

  assign dv_v[0] = ve;
  assign dv_d[0] = de;
  assign dv_s[0] = se;

  for (genvar g = 0; g < ND; g++) begin : g_div
    v3n_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dv_v[g]),
      .din  (dv_d[g]),
      .sin  (dv_s[g]),
      .vout (dv_v[g+1]),
      .dout (dv_d[g+1]),
      .sout (dv_s[g+1])
    );
  end

  // Final selection by mode into the output register.
  v3n_pkg::side_t    fs;
  v3n_pkg::result_t  res_next;
  logic [2:0][W-1:0] rv;
  logic              rsat;
  v3n_pkg::clamp_t   qcl;

  always_comb begin
    fs   = dv_s[ND];
    rv   = '0;
    rsat = 1'b0;
    qcl  = '0;
    case (fs.mode)
      v3n_pkg::MODE_ADD, v3n_pkg::MODE_SUB, v3n_pkg::MODE_SCALE: begin
        rv   = fs.re;
        rsat = fs.sat;
      end
      v3n_pkg::MODE_DIV, v3n_pkg::MODE_NORM: begin
        if (!fs.zero) begin
          for (int i = 0; i < 3; i++) begin
            qcl   = v3n_pkg::clamp_mag(fs.neg[i], dv_d[ND].num[i]);
            rv[i] = qcl.v;
            rsat  = rsat | qcl.sat;
          end
        end
      end
      default: begin
        rv = '0;
      end
    endcase
    res_next.r_x = 32'(signed'(rv[0]));
    res_next.r_y = 32'(signed'(rv[1]));
    res_next.r_z = 32'(signed'(rv[2]));
    if (fs.zero) begin
      res_next.status = v3n_pkg::ST_ZERO;
    end else if (rsat) begin
      res_next.status = v3n_pkg::ST_SAT;
    end else begin
      res_next.status = v3n_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_v[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

  // The chain only stops for a result that is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without a held result");

  // A zero divisor or zero vector must come out as the zero vector.
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == v3n_pkg::ST_ZERO) |->
      (result.r_x == '0 && result.r_y == '0 && result.r_z == '0))
    else $error("error status with a nonzero result");

  // A held result must not be disturbed by the frozen chain.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("held result changed");

  // Saturation status needs at least one component at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == v3n_pkg::ST_SAT) |->
      (result.r_x[30:0] == '1 || result.r_x[30:0] == '0 ||
       result.r_y[30:0] == '1 || result.r_y[30:0] == '0 ||
       result.r_z[30:0] == '1 || result.r_z[30:0] == '0))
    else $error("saturation status without a clamped component");

endmodule

### verif/vector3_arithmetic_normalize_tb.sv
`timescale 1ns / 1ps

module vector3_arithmetic_normalize_tb;

  // The unit holds each item for the length of its chain, so the drain wait after
  // the last result and the timeout are both sized well above that chain.
  localparam int LATENCY     = 86;
  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  v3n_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  v3n_pkg::result_t result;

  vector3_arithmetic_normalize DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  // Results still owed by the unit, oldest first.
  v3n_pkg::result_t pending_results[$];
  int      error_count;
  int      cycle_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Signed value of a 32-bit word, widened so that no intermediate overflows.
  function automatic longint word_value(input logic [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Clamp a magnitude with a sign to the 32-bit range; flags saturation.
  function automatic logic [31:0] clamp_word(input logic neg, input logic [63:0] m,
                                             inout logic sat);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-m) : 32'(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Works out the result that the vector unit must return for one item.
  function automatic v3n_pkg::result_t vector_result(input v3n_pkg::item_t it);
    v3n_pkg::result_t r;
    longint      a[3];
    longint      b[3];
    longint      s;
    logic [31:0] comp[3];
    logic [63:0] m;
    logic [63:0] sum;
    logic [63:0] len;
    logic        sat;
    logic        zero;
    a[0] = word_value(it.a_x);
    a[1] = word_value(it.a_y);
    a[2] = word_value(it.a_z);
    b[0] = word_value(it.b_x);
    b[1] = word_value(it.b_y);
    b[2] = word_value(it.b_z);
    s = word_value(it.scalar);
    sat = 1'b0;
    zero = 1'b0;
    for (int i = 0; i < 3; i++) comp[i] = '0;
    case (it.mode)
      v3n_pkg::MODE_ADD: begin
        for (int i = 0; i < 3; i++)
          comp[i] = clamp_word(a[i] + b[i] < 0, mag64(a[i] + b[i]), sat);
      end
      v3n_pkg::MODE_SUB: begin
        for (int i = 0; i < 3; i++)
          comp[i] = clamp_word(a[i] - b[i] < 0, mag64(a[i] - b[i]), sat);
      end
      v3n_pkg::MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          m = (mag64(a[i]) * mag64(s) + (64'd1 << (v3n_pkg::FRAC_BITS - 1)))
              >> v3n_pkg::FRAC_BITS;
          comp[i] = clamp_word((a[i] < 0) != (s < 0), m, sat);
        end
      end
      v3n_pkg::MODE_DIV: begin
        if (s == 0) begin
          zero = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            m = ((mag64(a[i]) << v3n_pkg::FRAC_BITS) + mag64(s) / 2) / mag64(s);
            comp[i] = clamp_word((a[i] < 0) != (s < 0), m, sat);
          end
        end
      end
      v3n_pkg::MODE_NORM: begin
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + mag64(a[i]) * mag64(a[i]);
        if (sum == 0) begin
          zero = 1'b1;
        end else begin
          len = int_sqrt(sum);
          for (int i = 0; i < 3; i++) begin
            m = ((mag64(a[i]) << v3n_pkg::FRAC_BITS) + len / 2) / len;
            comp[i] = clamp_word(a[i] < 0, m, sat);
          end
        end
      end
      default: ;
    endcase
    r.r_x = comp[0];
    r.r_y = comp[1];
    r.r_z = comp[2];
    r.status = zero ? v3n_pkg::ST_ZERO : (sat ? v3n_pkg::ST_SAT : v3n_pkg::ST_OK);
    return r;
  endfunction

  // Sends one item and records its expected result once the transfer happens.
  // Valid stays high between back-to-back items; it only drops for an idle gap.
  task automatic send_item(input v3n_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(vector_result(it));
  endtask

  task automatic release_input();
    item_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return 32'($signed(16'($urandom))) <<< $urandom_range(0, 16);
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic v3n_pkg::item_t make_item(input logic [2:0] mode,
                                               input logic [31:0] ax,
                                               input logic [31:0] ay, input logic [31:0] az,
                                               input logic [31:0] bx, input logic [31:0] by,
                                               input logic [31:0] bz, input logic [31:0] sc);
    v3n_pkg::item_t it;
    it.mode = mode;
    it.a_x = ax;
    it.a_y = ay;
    it.a_z = az;
    it.b_x = bx;
    it.b_y = by;
    it.b_z = bz;
    it.scalar = sc;
    return it;
  endfunction

  task automatic wait_for_drain();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Directed corners: field extremes, every mode, saturation in each
  // direction, divide by zero, the zero vector and the unused mode codes.
  task automatic test_directed();
    logic [31:0] mx;
    logic [31:0] mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_item(make_item(v3n_pkg::MODE_ADD, 32'h0001_0000, mn, mx, 32'h0002_0000, mn,
                        32'd1, 0));
    send_item(make_item(v3n_pkg::MODE_ADD, mx, mn, 0, mx, mn, 0, 32'hFFFF_FFFF));
    send_item(make_item(v3n_pkg::MODE_SUB, mn, mx, 32'h0003_8000, mx, mn, 32'h0001_0000,
                        0));
    send_item(make_item(v3n_pkg::MODE_SUB, 0, 0, 0, mn, mx, 32'hFFFF_FFFF, 0));
    send_item(make_item(v3n_pkg::MODE_SCALE, 32'h0002_0000, 32'hFFFF_0000, 32'd3, 0, 0, 0,
                        32'h0001_8000));
    send_item(make_item(v3n_pkg::MODE_SCALE, mx, mn, 32'd1, mx, mn, mx, mn));
    send_item(make_item(v3n_pkg::MODE_SCALE, mn, mx, 32'h0000_8000, 0, 0, 0, 32'd1));
    send_item(make_item(v3n_pkg::MODE_SCALE, 32'h0001_0000, 32'd5, mn, 0, 0, 0, 0));
    send_item(make_item(v3n_pkg::MODE_DIV, 32'h0003_0000, 32'hFFFD_0000, 32'd1, 0, 0, 0,
                        32'h0002_0000));
    send_item(make_item(v3n_pkg::MODE_DIV, mx, mn, 32'd5, 0, 0, 0, 32'd1));
    send_item(make_item(v3n_pkg::MODE_DIV, mx, mn, mx, 0, 0, 0, mn));
    send_item(make_item(v3n_pkg::MODE_DIV, 32'h0001_0000, mx, mn, mx, mx, mx, 0));
    send_item(make_item(v3n_pkg::MODE_DIV, 32'd3, 32'hFFFF_FFFD, 0, 0, 0, 0,
                        32'hFFFF_FFFF));
    send_item(make_item(v3n_pkg::MODE_NORM, 32'h0003_0000, 32'h0004_0000, 0, mx, mx, mx,
                        mx));
    send_item(make_item(v3n_pkg::MODE_NORM, mn, mn, mn, 0, 0, 0, 0));
    send_item(make_item(v3n_pkg::MODE_NORM, mx, 0, 0, 0, 0, 0, 0));
    send_item(make_item(v3n_pkg::MODE_NORM, 0, 32'd1, 0, 0, 0, 0, 0));
    send_item(make_item(v3n_pkg::MODE_NORM, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    send_item(make_item(v3n_pkg::MODE_NORM, 0, 0, 0, mx, mn, mx, mx));
    send_item(make_item(3'd5, mx, mn, 32'd7, mx, mn, 32'd7, mx));
    send_item(make_item(3'd6, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7));
    send_item(make_item(3'd7, mn, mn, mn, mn, mn, mn, mn));
    // Hold off until the unit has emptied, then carry on.
    wait_for_drain();
  endtask

  // Random items across all modes, with an occasional zero divisor or vector.
  task automatic test_random(input int count);
    v3n_pkg::item_t it;
    for (int n = 0; n < count; n++) begin
      it = make_item(($urandom_range(15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                     rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word());
      if ($urandom_range(19) == 0) it.scalar = '0;
      if ($urandom_range(19) == 0) begin
        it.a_x = '0;
        it.a_y = '0;
        it.a_z = '0;
      end
      send_item(it);
    end
    release_input();
  endtask

  // Receiver stall and result checking, field by field, against the oldest
  // expectation.
  always @(posedge clk) begin
    v3n_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.r_x !== want.r_x)
            $display("%0t: r_x expected %h actual %h", $time, want.r_x, result.r_x);
          if (result.r_y !== want.r_y)
            $display("%0t: r_y expected %h actual %h", $time, want.r_y, result.r_y);
          if (result.r_z !== want.r_z)
            $display("%0t: r_z expected %h actual %h", $time, want.r_z, result.r_z);
          if (result.status !== want.status)
            $display("%0t: status expected %h actual %h", $time, want.status,
                     result.status);
          if (result !== want) error_count++;
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[vector3_arithmetic_normalize] ERROR");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 22;
    recv_idle_pct = 65;
    test_directed();
    test_random(500);
    send_idle_pct = 65;
    recv_idle_pct = 22;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("[vector3_arithmetic_normalize] OK");
    end else begin
      $display("[vector3_arithmetic_normalize] ERROR");
    end
    $finish;
  end

endmodule
